>>> rtl/lfi_pkg.sv
// Shared types and constants of the leapfrog integration step.
package lfi_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MUL_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ENERGY_W = 63;

  localparam logic [CFG_DATA_W-1:0] DT_OVER_MASS_RST = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0] TIME_STEP_RST = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0] VELOCITY_SCALE_RST = 32'h4000_0000;
  localparam logic [CFG_DATA_W-1:0] PARTICLE_MASS_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DT_OVER_MASS   = 2'd0,
    CFG_TIME_STEP      = 2'd1,
    CFG_VELOCITY_SCALE = 2'd2,
    CFG_PARTICLE_MASS  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] velocity_in;
    logic signed [31:0] force_in;
    logic signed [31:0] position_in;
    logic               last_component;
  } in_t;

  typedef struct packed {
    logic signed [31:0]   velocity_out;
    logic signed [31:0]   position_out;
    logic [ENERGY_W-1:0]  energy_new_half;
    logic [ENERGY_W-1:0]  energy_midpoint;
    logic                 last_result;
  } out_t;

endpackage

>>> rtl/lfi_mul.sv
// Shared unsigned multiplier with a registered product.
module lfi_mul (
  input  logic                          clk_i,
  input  logic [lfi_pkg::MUL_W-1:0]     a_i,
  input  logic [lfi_pkg::MUL_W-1:0]     b_i,
  output logic [2*lfi_pkg::MUL_W-1:0]   prod_o
);
  import lfi_pkg::*;

  logic [2*MUL_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/leapfrog_integration_step.sv
// Top level of the leapfrog integration step with velocity scaling.
// Each item is one Cartesian component. A small sequencer drives a single
// registered 32 by 32 multiplier through the dependent products of the update.
// A result is loaded into the output register when its item has passed through
// the sequencer, which returns to idle as it loads, so the next item can then be
// accepted. A component marked last passes through further states, in which four
// products form the two kinetic energies and the sums are cleared. The input is
// ready only while the sequencer is idle; a finished result waits in the output
// register, and the next item is accepted while it waits. If the previous result
// is still waiting when a new one is ready, the sequencer holds until the output
// register is free.
module leapfrog_integration_step #(
  parameter int VALUE_WIDTH = lfi_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  lfi_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output lfi_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [lfi_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lfi_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import lfi_pkg::*;

  localparam int SatW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam logic signed [49:0] SatHi = (50'sd1 <<< (SatW - 1)) - 50'sd1;
  localparam logic signed [49:0] SatLo = -SatHi - 50'sd1;
  localparam logic [50:0] MagPos = (51'd1 << (SatW - 1)) - 51'd1;
  localparam logic [50:0] MagNeg = 51'd1 << (SatW - 1);
  localparam logic [63:0] Mask63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_FDT, S_RT, S_TS, S_SLO, S_SHI, S_VN, S_XT, S_VSQ, S_MSQ,
    S_MACC, S_ENLO, S_ENHI, S_EMLO, S_EMHI, S_EMF, S_OUT
  } state_e;

  state_e state_q;

  logic [31:0] dt_q, ts_q, scale_q, mass_q;

  logic signed [31:0] v_q, x_q, vn_q, xn_q;
  logic [31:0]        fmag_q, vmag_q;
  logic               fneg_q, tneg_q, vneg_q, last_q;
  logic [47:0]        rnd_q, tmag_q;
  logic [63:0]        lo_q, a_q;
  logic [32:0]        mmag_q;
  logic [63:0]        sum_new_q, sum_mid_q;
  logic [ENERGY_W-1:0] en_q, em_q;
  logic               out_valid_q;
  out_t               out_q;

  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;

  logic [63:0]        prod_rnd;
  logic signed [49:0] t_sum, x_sum;
  logic [49:0]        t_neg;
  logic [63:0]        lo_rnd;
  logic [50:0]        vn_wide;
  logic [32:0]        mid, mid_neg;
  logic [63:0]        msq;
  logic [64:0]        new_acc, mid_acc;
  logic               load_out;

  function automatic logic signed [31:0] sat_val(input logic signed [49:0] x);
    logic signed [49:0] c;
    begin
      if (x > SatHi) begin
        c = SatHi;
      end else if (x < SatLo) begin
        c = SatLo;
      end else begin
        c = x;
      end
      return c[31:0];
    end
  endfunction

  function automatic logic [ENERGY_W-1:0] energy_of(input logic [63:0] a,
                                                    input logic [63:0] b,
                                                    input int k);
    logic [64:0] a2;
    logic [64:0] lowpart;
    logic [64:0] r;
    begin
      a2 = {1'b0, a} + (65'd1 << (k - 1));
      lowpart = a2 >> k;
      r = ({1'b0, b} << (32 - k)) + lowpart;
      if (b > (Mask63 >> (32 - k))) begin
        return Mask63[ENERGY_W-1:0];
      end else if (r > {1'b0, Mask63}) begin
        return Mask63[ENERGY_W-1:0];
      end else begin
        return r[ENERGY_W-1:0];
      end
    end
  endfunction

  lfi_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    case (state_q)
      S_FDT: begin
        mul_a = fmag_q;
        mul_b = dt_q;
      end
      S_SLO: begin
        mul_a = tmag_q[31:0];
        mul_b = scale_q;
      end
      S_SHI: begin
        mul_a = {16'd0, tmag_q[47:32]};
        mul_b = scale_q;
      end
      S_XT: begin
        mul_a = vmag_q;
        mul_b = ts_q;
      end
      S_VSQ: begin
        mul_a = vmag_q;
        mul_b = vmag_q;
      end
      S_MSQ: begin
        mul_a = mmag_q[31:0];
        mul_b = mmag_q[31:0];
      end
      S_ENLO: begin
        mul_a = sum_new_q[31:0];
        mul_b = mass_q;
      end
      S_ENHI: begin
        mul_a = sum_new_q[63:32];
        mul_b = mass_q;
      end
      S_EMLO: begin
        mul_a = sum_mid_q[31:0];
        mul_b = mass_q;
      end
      S_EMHI: begin
        mul_a = sum_mid_q[63:32];
        mul_b = mass_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_rnd = prod + 64'd32768;
    t_sum = {{18{v_q[31]}}, v_q}
          + (fneg_q ? -$signed({2'b00, rnd_q}) : $signed({2'b00, rnd_q}));
    t_neg = -t_sum;
    x_sum = {{18{x_q[31]}}, x_q}
          + (vneg_q ? -$signed({2'b00, rnd_q}) : $signed({2'b00, rnd_q}));
    lo_rnd = lo_q + 64'h2000_0000;
    vn_wide = {1'b0, prod[47:0], 2'b00} + {17'd0, lo_rnd[63:30]};
    mid = {v_q[31], v_q} + {vn_q[31], vn_q};
    mid_neg = -mid;
    msq = mmag_q[32] ? '1 : prod;
    new_acc = {1'b0, sum_new_q} + {1'b0, prod};
    mid_acc = {1'b0, sum_mid_q} + {1'b0, msq};
    load_out = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q    <= DT_OVER_MASS_RST;
      ts_q    <= TIME_STEP_RST;
      scale_q <= VELOCITY_SCALE_RST;
      mass_q  <= PARTICLE_MASS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DT_OVER_MASS:   dt_q    <= cfg_data_i;
        CFG_TIME_STEP:      ts_q    <= cfg_data_i;
        CFG_VELOCITY_SCALE: scale_q <= cfg_data_i;
        CFG_PARTICLE_MASS:  mass_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      v_q         <= '0;
      x_q         <= '0;
      vn_q        <= '0;
      xn_q        <= '0;
      fmag_q      <= '0;
      vmag_q      <= '0;
      fneg_q      <= 1'b0;
      tneg_q      <= 1'b0;
      vneg_q      <= 1'b0;
      last_q      <= 1'b0;
      rnd_q       <= '0;
      tmag_q      <= '0;
      lo_q        <= '0;
      a_q         <= '0;
      mmag_q      <= '0;
      sum_new_q   <= '0;
      sum_mid_q   <= '0;
      en_q        <= '0;
      em_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            v_q    <= in_data_i.velocity_in;
            x_q    <= in_data_i.position_in;
            fneg_q <= in_data_i.force_in[31];
            fmag_q <= in_data_i.force_in[31] ? -in_data_i.force_in : in_data_i.force_in;
            last_q <= in_data_i.last_component;
            en_q   <= '0;
            em_q   <= '0;
            state_q <= S_FDT;
          end
        end
        S_FDT: state_q <= S_RT;
        S_RT: begin
          rnd_q   <= prod_rnd[63:16];
          state_q <= S_TS;
        end
        S_TS: begin
          tneg_q  <= t_sum[49];
          tmag_q  <= t_sum[49] ? t_neg[47:0] : t_sum[47:0];
          state_q <= S_SLO;
        end
        S_SLO: state_q <= S_SHI;
        S_SHI: begin
          lo_q    <= prod;
          state_q <= S_VN;
        end
        S_VN: begin
          vneg_q <= tneg_q;
          if (tneg_q) begin
            vmag_q <= (vn_wide > MagNeg) ? MagNeg[31:0] : vn_wide[31:0];
          end else begin
            vmag_q <= (vn_wide > MagPos) ? MagPos[31:0] : vn_wide[31:0];
          end
          state_q <= S_XT;
        end
        S_XT: begin
          vn_q    <= vneg_q ? -vmag_q : vmag_q;
          state_q <= S_VSQ;
        end
        S_VSQ: begin
          rnd_q   <= prod_rnd[63:16];
          mmag_q  <= mid[32] ? mid_neg : mid;
          state_q <= S_MSQ;
        end
        S_MSQ: begin
          xn_q      <= sat_val(x_sum);
          sum_new_q <= new_acc[64] ? '1 : new_acc[63:0];
          state_q   <= S_MACC;
        end
        S_MACC: begin
          sum_mid_q <= mid_acc[64] ? '1 : mid_acc[63:0];
          state_q   <= last_q ? S_ENLO : S_OUT;
        end
        S_ENLO: state_q <= S_ENHI;
        S_ENHI: begin
          a_q     <= prod;
          state_q <= S_EMLO;
        end
        S_EMLO: begin
          en_q    <= energy_of(a_q, prod, 17);
          state_q <= S_EMHI;
        end
        S_EMHI: begin
          a_q     <= prod;
          state_q <= S_EMF;
        end
        S_EMF: begin
          em_q      <= energy_of(a_q, prod, 19);
          sum_new_q <= '0;
          sum_mid_q <= '0;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (load_out) begin
            out_q.velocity_out    <= vn_q;
            out_q.position_out    <= xn_q;
            out_q.energy_new_half <= en_q;
            out_q.energy_midpoint <= em_q;
            out_q.last_result     <= last_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted again while an item is in progress.");

  a_energy_zero_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_result |->
      (out_data_o.energy_new_half == '0) && (out_data_o.energy_midpoint == '0))
    else $error("Energies reported on an item that is not last.");

  a_sums_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) && last_q |-> (sum_new_q == '0) && (sum_mid_q == '0))
    else $error("Energy sums not cleared after the last item.");

endmodule

>>> sim/tb.sv
// Self-checking testbench for leapfrog_integration_step against a built-in bit-exact predictor.
`timescale 1ns / 100ps

module tb;
  import lfi_pkg::*;

  localparam longint VEL_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint VEL_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CFG_DT_OVER_MASS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [31:0] dt_over_mass_q = DT_OVER_MASS_RST;
  logic [31:0] time_step_q = TIME_STEP_RST;
  logic [31:0] vel_scale_q = VELOCITY_SCALE_RST;
  logic [31:0] mass_q = PARTICLE_MASS_RST;
  logic [63:0] sum_new_sq = '0;
  logic [63:0] sum_mid_sq = '0;

  out_t pending_updates[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  leapfrog_integration_step dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(3_000_000);
    $display("leapfrog_integration_step test failed");
    $finish;
  end

  // Signed value times an unsigned word, rounded half away from zero by sh bits.
  function automatic longint mul_round(longint a, logic [31:0] b, int unsigned sh);
    logic [127:0] prod;
    prod = 128'(a < 0 ? -a : a) * 128'(b) + (128'd1 << (sh - 1));
    prod = prod >> sh;
    return (a < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint clamp32(longint a);
    if (a > VEL_MAX) return VEL_MAX;
    if (a < VEL_MIN) return VEL_MIN;
    return a;
  endfunction

  function automatic logic [ENERGY_W-1:0] kinetic_energy(logic [63:0] sum, logic [31:0] mass,
                                                         int unsigned k);
    logic [127:0] prod;
    prod = (128'(sum) * 128'(mass) + (128'd1 << (k - 1))) >> k;
    return (prod > 128'(ENERGY_MAX)) ? ENERGY_MAX : prod[ENERGY_W-1:0];
  endfunction

  function automatic out_t integrate_component(in_t c);
    longint v, x, vn, xn, mid;
    logic [63:0] vmag, mmag, mid_sq;
    logic [64:0] acc;
    out_t r;
    v = longint'(c.velocity_in);
    x = longint'(c.position_in);
    vn = clamp32(mul_round(v + mul_round(longint'(c.force_in), dt_over_mass_q, 16),
                           vel_scale_q, 30));
    xn = clamp32(x + mul_round(vn, time_step_q, 16));
    vmag = 64'(vn < 0 ? -vn : vn);
    acc = 65'(sum_new_sq) + 65'(vmag * vmag);
    sum_new_sq = acc[64] ? '1 : acc[63:0];
    mid = v + vn;
    mmag = 64'(mid < 0 ? -mid : mid);
    mid_sq = (mmag > 64'hFFFF_FFFF) ? '1 : mmag * mmag;
    acc = 65'(sum_mid_sq) + 65'(mid_sq);
    sum_mid_sq = acc[64] ? '1 : acc[63:0];
    r.velocity_out = vn[31:0];
    r.position_out = xn[31:0];
    if (c.last_component) begin
      r.energy_new_half = kinetic_energy(sum_new_sq, mass_q, 17);
      r.energy_midpoint = kinetic_energy(sum_mid_sq, mass_q, 19);
      sum_new_sq = '0;
      sum_mid_sq = '0;
    end else begin
      r.energy_new_half = '0;
      r.energy_midpoint = '0;
    end
    r.last_result = c.last_component;
    return r;
  endfunction

  task automatic check_field(input string field_name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, field_name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : take_result
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected item expected none, got %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_updates.pop_front();
        check_field("velocity_out", 64'(want.velocity_out), 64'(out_data.velocity_out));
        check_field("position_out", 64'(want.position_out), 64'(out_data.position_out));
        check_field("energy_new_half", 64'(want.energy_new_half),
                    64'(out_data.energy_new_half));
        check_field("energy_midpoint", 64'(want.energy_midpoint),
                    64'(out_data.energy_midpoint));
        check_field("last_result", 64'(want.last_result), 64'(out_data.last_result));
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic in_t make_component(logic [31:0] v, logic [31:0] f, logic [31:0] x,
                                         logic last);
    in_t c;
    c.velocity_in = v;
    c.force_in = f;
    c.position_in = x;
    c.last_component = last;
    return c;
  endfunction

  task automatic send_component(input in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_updates.push_back(integrate_component(c));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] dt, input logic [31:0] ts,
                              input logic [31:0] scale, input logic [31:0] mass);
    cfg_idx_e idx;
    logic [31:0] word [4];
    word = '{dt, ts, scale, mass};
    idx = idx.first();
    repeat (4) begin
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      cfg_data <= word[int'(idx)];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    dt_over_mass_q = dt;
    time_step_q = ts;
    vel_scale_q = scale;
    mass_q = mass;
  endtask

  function automatic logic [31:0] pick_corner_word();
    case ($urandom_range(2))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(3))
      0: return r;
      1: return {{14{r[31]}}, r[17:0]};
      2: return {{6{r[31]}}, r[25:0]};
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0001;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  task automatic test_reset_values();
    send_component(make_component(32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_component(make_component(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send_component(make_component(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1));
    drain_results();
  endtask

  task automatic test_field_extremes();
    program_regs('1, '1, '1, '1);
    send_component(make_component(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_component(make_component(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_component(make_component(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0));
    send_component(make_component(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1));
    drain_results();
    program_regs('0, '0, '0, '0);
    send_component(make_component(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    drain_results();
  endtask

  task automatic test_rounding();
    program_regs(32'h0000_8000, 32'h0000_8000, 32'h2000_0000, 32'h0001_8000);
    send_component(make_component(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b0));
    send_component(make_component(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
    send_component(make_component(32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0005, 1'b1));
    drain_results();
  endtask

  task automatic test_sum_saturation();
    program_regs('0, 32'h0001_0000, 32'h4000_0000, '1);
    for (int i = 0; i < 5; i++) begin
      send_component(make_component(32'h8000_0000, $urandom, 32'h7FFF_FFFF, i == 4));
    end
    drain_results();
  endtask

  task automatic test_random_steps(input int round, input int n_items);
    int sent;
    int len;
    case (round % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
    case (round % 3)
      0: program_regs($urandom_range(32'h0002_0000), $urandom_range(32'h0001_0000),
                      $urandom_range(32'h3800_0000, 32'h4800_0000),
                      $urandom_range(32'h0000_1000, 32'h0010_0000));
      1: program_regs($urandom, $urandom, $urandom, $urandom);
      default: program_regs(pick_corner_word(), pick_corner_word(), pick_corner_word(),
                            pick_corner_word());
    endcase
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, 9);
        for (int i = 1; i <= len; i++) begin
          send_component(make_component(pick_value(), pick_value(), pick_value(), i == len));
        end
        sent += len;
      end else begin
        send_component(make_component(pick_value(), pick_value(), pick_value(),
                                      $urandom_range(1)));
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin
    @(posedge rst_n);
    @(posedge clk);
    test_reset_values();
    test_field_extremes();
    test_rounding();
    test_sum_saturation();
    for (int round = 0; round < 8; round++) begin
      test_random_steps(round, 168);
    end
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_updates.size() == 0) begin
      $display("leapfrog_integration_step test passed");
    end else begin
      $display("leapfrog_integration_step test failed");
    end
    $finish;
  end

endmodule
